// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock outside reset
`define SSC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ssc assertion failed");

// signal must hold its value in the cycle after cond
`define SSC_ASSERT_STABLE(name, clk, rst_n, cond, sig) \
    name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error("ssc stability assertion failed");

`endif

// File: rtl/core/ssc_pkg.sv
// shared constants and types of the stone score classifier
// no dependencies
package ssc_pkg;

    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 31;
    localparam int DIV_HI_W  = DIV_NUM_W - DIV_Q_W;
    localparam int DIV_LAT   = DIV_Q_W + 1;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 184;

    localparam logic signed [31:0] EMPTY_BIAS           = 32'sd0;
    localparam logic [30:0]        EMPTY_Z_WEIGHT       = 31'd65536;
    localparam logic [30:0]        EMPTY_SUPPORT_WEIGHT = 31'd65536;
    localparam logic [30:0]        CHROMA_CONF_WEIGHT   = 31'd0;

    localparam logic [16:0] Q_ONE = 17'd65536;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CLS_BLACK,
        CLS_WHITE,
        CLS_EMPTY
    } stone_class_t;

    typedef enum logic [2:0] {
        REG_EMPTY_MEDIAN,
        REG_EMPTY_SIGMA,
        REG_CHROMA_THR_SQ,
        REG_WEIGHT_DELTA,
        REG_WEIGHT_SUPPORT,
        REG_WEIGHT_CHROMA,
        REG_MARGIN_BASE,
        REG_EDGE_PENALTY
    } cfg_reg_t;

endpackage

// File: rtl/core/ssc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ssc_pkg
module ssc_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [ssc_pkg::DIV_NUM_W-1:0]  num,
    input  logic [ssc_pkg::DIV_DEN_W-1:0]  den,
    output logic [ssc_pkg::DIV_Q_W-1:0]    quot,
    output logic                           ovf
);

    logic [ssc_pkg::DIV_DEN_W-1:0] rem_reg  [ssc_pkg::DIV_LAT];
    logic [ssc_pkg::DIV_Q_W-1:0]   low_reg  [ssc_pkg::DIV_LAT];
    logic [ssc_pkg::DIV_DEN_W-1:0] den_reg  [ssc_pkg::DIV_LAT];
    logic [ssc_pkg::DIV_Q_W-1:0]   quot_reg [ssc_pkg::DIV_LAT];
    logic                          ovf_reg  [ssc_pkg::DIV_LAT];

    logic [ssc_pkg::DIV_DEN_W:0]   cand     [ssc_pkg::DIV_LAT];
    logic [ssc_pkg::DIV_DEN_W:0]   diff     [ssc_pkg::DIV_LAT];
    logic                          ge       [ssc_pkg::DIV_LAT];
    logic [ssc_pkg::DIV_DEN_W-1:0] rem_init;

    assign rem_init = {{(ssc_pkg::DIV_DEN_W - ssc_pkg::DIV_HI_W){1'b0}},
                       num[ssc_pkg::DIV_NUM_W-1:ssc_pkg::DIV_Q_W]};

    always_comb
    begin
        cand[0] = '0;
        diff[0] = '0;
        ge[0]   = 1'b0;
        for (int k = 1; k < ssc_pkg::DIV_LAT; k++)
        begin
            cand[k] = {rem_reg[k-1], low_reg[k-1][ssc_pkg::DIV_Q_W-1]};
            diff[k] = cand[k] - {1'b0, den_reg[k-1]};
            ge[k]   = cand[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_init;
            low_reg[0]  <= num[ssc_pkg::DIV_Q_W-1:0];
            den_reg[0]  <= den;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= rem_init >= den;
            for (int k = 1; k < ssc_pkg::DIV_LAT; k++)
            begin
                rem_reg[k]  <= ge[k] ? diff[k][ssc_pkg::DIV_DEN_W-1:0]
                                     : cand[k][ssc_pkg::DIV_DEN_W-1:0];
                low_reg[k]  <= {low_reg[k-1][ssc_pkg::DIV_Q_W-2:0], 1'b0};
                den_reg[k]  <= den_reg[k-1];
                quot_reg[k] <= {quot_reg[k-1][ssc_pkg::DIV_Q_W-2:0], ge[k]};
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end
    end

    assign quot = quot_reg[ssc_pkg::DIV_LAT-1];
    assign ovf  = ovf_reg[ssc_pkg::DIV_LAT-1];

endmodule

// File: rtl/core/stone_score_classifier.sv
// stone score classifier: z-score, chroma penalty, class scores, confidence
// throughput: one cell per cycle while the result side is not stalled; every stage,
// the three 32-stage dividers included, is pipelined
// a stall on the result side holds every stage at once, nothing is dropped
// reset: asynchronous, active low; clears valid bits and loads register defaults
// depends on ssc_pkg and ssc_div
module stone_score_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // lum_delta, dark_fraction, bright_fraction, chroma_sq, edge_level
    input  logic [ssc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // stone_class, z_score, best_score, second_score, score_margin,
    // required_margin, confidence
    output logic [ssc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [31:0]                    cfg_data
);

    typedef struct packed {
        logic               neg;
        logic signed [17:0] sb;
        logic [17:0]        sdb;
        logic [30:0]        req;
    } zside_t;

    typedef struct packed {
        ssc_pkg::stone_class_t cls;
        logic signed [31:0]    z;
        logic signed [31:0]    best;
        logic signed [31:0]    second;
        logic [30:0]           margin;
        logic [30:0]           req;
        logic [16:0]           cf;
    } cside_t;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
        logic signed [31:0] r;
        if (x > 51'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -51'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] trunc_q(input logic signed [63:0] x);
        logic signed [47:0] r;
        r = x[63:16];
        if (x[63] && (x[15:0] != 16'd0))
            r = r + 48'sd1;
        return r;
    endfunction

    // configuration
    logic signed [31:0] median_reg, wd_reg, ws_reg, wc_reg;
    logic [30:0]        sigma_reg, cthr_reg, mbase_reg, epen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg <= 32'sd0;
            sigma_reg  <= 31'd65536;
            cthr_reg   <= 31'd65536;
            wd_reg     <= 32'sd65536;
            ws_reg     <= 32'sd65536;
            wc_reg     <= 32'sd65536;
            mbase_reg  <= 31'd65536;
            epen_reg   <= 31'd0;
        end
        else if (cfg_valid)
        begin
            unique case (ssc_pkg::cfg_reg_t'(cfg_index))
                ssc_pkg::REG_EMPTY_MEDIAN:   median_reg <= cfg_data;
                ssc_pkg::REG_EMPTY_SIGMA:    sigma_reg  <= cfg_data[30:0];
                ssc_pkg::REG_CHROMA_THR_SQ:  cthr_reg   <= cfg_data[30:0];
                ssc_pkg::REG_WEIGHT_DELTA:   wd_reg     <= cfg_data;
                ssc_pkg::REG_WEIGHT_SUPPORT: ws_reg     <= cfg_data;
                ssc_pkg::REG_WEIGHT_CHROMA:  wc_reg     <= cfg_data;
                ssc_pkg::REG_MARGIN_BASE:    mbase_reg  <= cfg_data[30:0];
                ssc_pkg::REG_EDGE_PENALTY:   epen_reg   <= cfg_data[30:0];
            endcase
        end
    end

    // global advance
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;

    logic signed [31:0] lum_in;
    logic [16:0]        dark_in, bright_in;
    logic [30:0]        csq_in;
    logic [1:0]         edge_in;

    assign lum_in    = s_tdata[31:0];
    assign dark_in   = s_tdata[48:32];
    assign bright_in = s_tdata[65:49];
    assign csq_in    = s_tdata[96:66];
    assign edge_in   = s_tdata[98:97];

    // valid bits
    logic va_reg, vb_reg, ve_reg, vf_reg, vg_reg, vh_reg, vi_reg, vj_reg, vk_reg, vl_reg;
    logic vz_reg [ssc_pkg::DIV_LAT];
    logic vc_reg [ssc_pkg::DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
            vl_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < ssc_pkg::DIV_LAT; k++)
            begin
                vz_reg[k] <= 1'b0;
                vc_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            va_reg    <= s_tvalid;
            vb_reg    <= va_reg;
            vz_reg[0] <= vb_reg;
            for (int k = 1; k < ssc_pkg::DIV_LAT; k++)
            begin
                vz_reg[k] <= vz_reg[k-1];
                vc_reg[k] <= vc_reg[k-1];
            end
            ve_reg    <= vz_reg[ssc_pkg::DIV_LAT-1];
            vf_reg    <= ve_reg;
            vg_reg    <= vf_reg;
            vh_reg    <= vg_reg;
            vi_reg    <= vh_reg;
            vj_reg    <= vi_reg;
            vc_reg[0] <= vj_reg;
            vk_reg    <= vc_reg[ssc_pkg::DIV_LAT-1];
            vl_reg    <= vk_reg;
            out_valid_reg <= vl_reg;
        end
    end

    // stage a: offsets and sums
    logic signed [32:0] diff_a_reg;
    logic [31:0]        denp_a_reg;
    logic [30:0]        csq_a_reg;
    logic [16:0]        dark_a_reg, bright_a_reg;
    logic [32:0]        epe_a_reg;

    // stage b: magnitudes, margin products
    logic [ssc_pkg::DIV_NUM_W-1:0] numz_b_reg, nump_b_reg;
    logic [31:0]                   denp_b_reg;
    logic                          neg_b_reg;
    logic signed [17:0]            sb_b_reg;
    logic [17:0]                   sdb_b_reg;
    logic [48:0]                   hi_b_reg;
    logic [46:0]                   lo_b_reg;

    logic [32:0] mag_a;
    logic [33:0] fac_a;

    assign mag_a = diff_a_reg[32] ? 33'(-diff_a_reg) : 33'(diff_a_reg);
    assign fac_a = 34'd65536 + {1'b0, epe_a_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_a_reg   <= 33'(lum_in) - 33'(median_reg);
            denp_a_reg   <= {1'b0, cthr_reg} + {1'b0, csq_in};
            csq_a_reg    <= csq_in;
            dark_a_reg   <= dark_in;
            bright_a_reg <= bright_in;
            epe_a_reg    <= ({2'b00, epen_reg} & {33{edge_in[0]}})
                          + ({1'b0, epen_reg, 1'b0} & {33{edge_in[1]}});

            numz_b_reg <= {mag_a, 16'd0};
            nump_b_reg <= {2'b00, csq_a_reg, 16'd0};
            denp_b_reg <= (denp_a_reg == 32'd0) ? 32'd1 : denp_a_reg;
            neg_b_reg  <= diff_a_reg[32];
            sb_b_reg   <= $signed({1'b0, dark_a_reg}) - $signed({1'b0, bright_a_reg});
            sdb_b_reg  <= {1'b0, dark_a_reg} + {1'b0, bright_a_reg};
            hi_b_reg   <= 49'(mbase_reg) * 49'(fac_a[33:16]);
            lo_b_reg   <= 47'(mbase_reg) * 47'(fac_a[15:0]);
        end
    end

    // z and penalty dividers
    logic [30:0] sigma_fix;
    logic [30:0] qz, qp;
    logic        ovz, ovp;

    assign sigma_fix = (sigma_reg == 31'd0) ? 31'd1 : sigma_reg;

    ssc_div u_div_z (
        .clk  (clk),
        .en   (adv),
        .num  (numz_b_reg),
        .den  ({1'b0, sigma_fix}),
        .quot (qz),
        .ovf  (ovz)
    );

    ssc_div u_div_p (
        .clk  (clk),
        .en   (adv),
        .num  (nump_b_reg),
        .den  (denp_b_reg),
        .quot (qp),
        .ovf  (ovp)
    );

    logic [49:0] req_sum_b;
    zside_t      zside_next;
    zside_t      zside_reg [ssc_pkg::DIV_LAT];
    zside_t      zs_end;

    assign req_sum_b = 50'(hi_b_reg) + 50'(lo_b_reg[46:16]);

    always_comb
    begin
        zside_next.neg = neg_b_reg;
        zside_next.sb  = sb_b_reg;
        zside_next.sdb = sdb_b_reg;
        zside_next.req = (req_sum_b > 50'(ssc_pkg::MAX31)) ? ssc_pkg::MAX31 : req_sum_b[30:0];
    end

    assign zs_end = zside_reg[ssc_pkg::DIV_LAT-1];

    // stage e: saturated z; f: products; g: truncation; h: scores
    logic signed [31:0] z_e_reg;
    logic [31:0]        az_e_reg;
    logic [16:0]        p_e_reg;
    logic signed [17:0] sb_e_reg;
    logic [17:0]        sdb_e_reg;
    logic [30:0]        req_e_reg;

    logic signed [63:0] pz_f_reg;
    logic signed [49:0] ps_f_reg, pc_f_reg;
    logic [62:0]        pez_f_reg;
    logic [48:0]        pes_f_reg;
    logic [47:0]        pcc_f_reg;
    logic signed [31:0] z_f_reg;
    logic [30:0]        req_f_reg;

    logic signed [47:0] mz_g_reg, ms_g_reg, mc_g_reg;
    logic [46:0]        mez_g_reg;
    logic [32:0]        mes_g_reg;
    logic [16:0]        cf_g_reg;
    logic signed [31:0] z_g_reg;
    logic [30:0]        req_g_reg;

    logic signed [31:0] blk_h_reg, wht_h_reg, emp_h_reg;
    logic [16:0]        cf_h_reg;
    logic signed [31:0] z_h_reg;
    logic [30:0]        req_h_reg;

    logic signed [31:0] z_sat_e;
    logic [31:0]        az_e;
    logic [31:0]        ccp_f;
    logic signed [50:0] blk_s, wht_s, emp_s;

    always_comb
    begin
        if (ovz)
        begin
            z_sat_e = zs_end.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            az_e    = zs_end.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            z_sat_e = zs_end.neg ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
            az_e    = {1'b0, qz};
        end
    end

    assign ccp_f = pcc_f_reg[47:16];

    assign blk_s = -51'(mz_g_reg) + 51'(ms_g_reg) - 51'(mc_g_reg);
    assign wht_s =  51'(mz_g_reg) - 51'(ms_g_reg) - 51'(mc_g_reg);
    assign emp_s =  51'(ssc_pkg::EMPTY_BIAS) - $signed({4'd0, mez_g_reg})
                  - $signed({18'd0, mes_g_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zside_reg[0] <= zside_next;
            for (int k = 1; k < ssc_pkg::DIV_LAT; k++)
                zside_reg[k] <= zside_reg[k-1];

            z_e_reg   <= z_sat_e;
            az_e_reg  <= az_e;
            p_e_reg   <= ovp ? ssc_pkg::Q_ONE : qp[16:0];
            sb_e_reg  <= zs_end.sb;
            sdb_e_reg <= zs_end.sdb;
            req_e_reg <= zs_end.req;

            pz_f_reg  <= 64'(wd_reg) * 64'(z_e_reg);
            ps_f_reg  <= 50'(ws_reg) * 50'(sb_e_reg);
            pc_f_reg  <= 50'(wc_reg) * 50'($signed({1'b0, p_e_reg}));
            pez_f_reg <= 63'(ssc_pkg::EMPTY_Z_WEIGHT) * 63'(az_e_reg);
            pes_f_reg <= 49'(ssc_pkg::EMPTY_SUPPORT_WEIGHT) * 49'(sdb_e_reg);
            pcc_f_reg <= 48'(ssc_pkg::CHROMA_CONF_WEIGHT) * 48'(p_e_reg);
            z_f_reg   <= z_e_reg;
            req_f_reg <= req_e_reg;

            mz_g_reg  <= trunc_q(pz_f_reg);
            ms_g_reg  <= trunc_q(64'(ps_f_reg));
            mc_g_reg  <= trunc_q(64'(pc_f_reg));
            mez_g_reg <= pez_f_reg[62:16];
            mes_g_reg <= pes_f_reg[48:16];
            cf_g_reg  <= (ccp_f > 32'(ssc_pkg::Q_ONE)) ? 17'd0 : ssc_pkg::Q_ONE - ccp_f[16:0];
            z_g_reg   <= z_f_reg;
            req_g_reg <= req_f_reg;

            blk_h_reg <= sat32(blk_s);
            wht_h_reg <= sat32(wht_s);
            emp_h_reg <= sat32(emp_s);
            cf_h_reg  <= cf_g_reg;
            z_h_reg   <= z_g_reg;
            req_h_reg <= req_g_reg;
        end
    end

    // stage i: best and second; j: margin
    ssc_pkg::stone_class_t cls_i;
    logic signed [31:0]    best_i, second_i;

    always_comb
    begin
        cls_i    = ssc_pkg::CLS_BLACK;
        best_i   = blk_h_reg;
        second_i = wht_h_reg;
        if (wht_h_reg > blk_h_reg)
        begin
            cls_i    = ssc_pkg::CLS_WHITE;
            best_i   = wht_h_reg;
            second_i = blk_h_reg;
        end
        priority if (emp_h_reg > best_i)
        begin
            cls_i    = ssc_pkg::CLS_EMPTY;
            best_i   = emp_h_reg;
            second_i = (blk_h_reg > wht_h_reg) ? blk_h_reg : wht_h_reg;
        end
        else if (emp_h_reg > second_i)
        begin
            second_i = emp_h_reg;
        end
        else
        begin
            second_i = second_i;
        end
    end

    ssc_pkg::stone_class_t cls_i_reg;
    logic signed [31:0]    best_i_reg, second_i_reg, z_i_reg;
    logic [16:0]           cf_i_reg;
    logic [30:0]           req_i_reg;

    logic signed [32:0] mdiff_i;
    logic [30:0]        margin_i;

    assign mdiff_i  = 33'(best_i_reg) - 33'(second_i_reg);
    assign margin_i = (mdiff_i[32:31] != 2'b00) ? ssc_pkg::MAX31 : mdiff_i[30:0];

    cside_t cside_j_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_i_reg    <= cls_i;
            best_i_reg   <= best_i;
            second_i_reg <= second_i;
            z_i_reg      <= z_h_reg;
            cf_i_reg     <= cf_h_reg;
            req_i_reg    <= req_h_reg;

            cside_j_reg.cls    <= cls_i_reg;
            cside_j_reg.z      <= z_i_reg;
            cside_j_reg.best   <= best_i_reg;
            cside_j_reg.second <= second_i_reg;
            cside_j_reg.margin <= margin_i;
            cside_j_reg.req    <= req_i_reg;
            cside_j_reg.cf     <= cf_i_reg;
        end
    end

    // confidence divider
    logic [30:0] qc;
    logic        ovc;

    ssc_div u_div_c (
        .clk  (clk),
        .en   (adv),
        .num  ({2'b00, cside_j_reg.margin, 16'd0}),
        .den  ({1'b0, cside_j_reg.req} + 32'd1),
        .quot (qc),
        .ovf  (ovc)
    );

    cside_t      cside_reg [ssc_pkg::DIV_LAT];
    cside_t      cside_k_reg, cside_l_reg, out_reg;
    logic [16:0] conf_k_reg;
    logic [33:0] cp_l_reg;
    logic [16:0] conf_out_reg;
    logic [17:0] conf_l;

    assign conf_l = cp_l_reg[33:16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cside_reg[0] <= cside_j_reg;
            for (int k = 1; k < ssc_pkg::DIV_LAT; k++)
                cside_reg[k] <= cside_reg[k-1];

            cside_k_reg <= cside_reg[ssc_pkg::DIV_LAT-1];
            conf_k_reg  <= (ovc || (qc > 31'(ssc_pkg::Q_ONE))) ? ssc_pkg::Q_ONE : qc[16:0];

            cside_l_reg <= cside_k_reg;
            cp_l_reg    <= 34'(conf_k_reg) * 34'(cside_k_reg.cf);

            out_reg      <= cside_l_reg;
            conf_out_reg <= (conf_l > 18'(ssc_pkg::Q_ONE)) ? ssc_pkg::Q_ONE : conf_l[16:0];
        end
    end

    assign m_tdata = {7'd0, conf_out_reg, out_reg.req, out_reg.margin, out_reg.second,
                      out_reg.best, out_reg.z, out_reg.cls};

endmodule

// File: rtl/core/ssc_checker.sv
// port-level checks of the stone score classifier, bound to the top level
// depends on ssc_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssc_pkg::M_TDATA_W-1:0] m_tdata
);

    `SSC_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid)
    `SSC_ASSERT_STABLE(a_data_hold, clk, rst_n, m_tvalid && !m_tready, m_tdata)
    `SSC_ASSERT(a_ready_flow, clk, rst_n, s_tready == (!m_tvalid || m_tready))
    `SSC_ASSERT(a_conf_range, clk, rst_n, m_tvalid |-> m_tdata[176:160] <= 17'd65536)
    `SSC_ASSERT(a_best_order, clk, rst_n, m_tvalid |-> $signed(m_tdata[65:34]) >= $signed(m_tdata[97:66]))

endmodule

bind stone_score_classifier ssc_checker u_ssc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/stone_score_classifier_test.sv
// self-checking testbench for stone_score_classifier: random cells, several settings
// depends on ssc_pkg and the stone_score_classifier rtl
module stone_score_classifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  edge_level;
        logic [30:0] chroma_sq;
        logic [16:0] bright_fraction;
        logic [16:0] dark_fraction;
        logic [31:0] lum_delta;
    } cell_t;

    typedef struct packed {
        logic [16:0]        confidence;
        logic [30:0]        required_margin;
        logic [30:0]        score_margin;
        logic signed [31:0] second_score;
        logic signed [31:0] best_score;
        logic signed [31:0] z_score;
        logic [1:0]         stone_class;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ssc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ssc_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    stone_score_classifier dut (.*);

    always #6 clk = ~clk;

    longint cal_median, cal_sigma, cal_cthr, cal_wd, cal_ws, cal_wc, cal_mbase, cal_epen;

    cell_t    cell_queue[$];
    verdict_t verdict_queue[$];
    int errors = 0;
    int cells_sent = 0;
    int verdicts_seen = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qprod(longint a, longint b);
        return (a * b) / 65536;
    endfunction

    function automatic verdict_t classify(cell_t c);
        verdict_t v;
        longint lum, dark, bright, csq, edge_lv, sig, z, den, pen, sb, az, cterm;
        longint sblk, swht, semp, best, second, margin, factor, req, conf, cf;
        logic [1:0] cls;
        lum = longint'($signed(c.lum_delta));
        dark = longint'(c.dark_fraction);
        bright = longint'(c.bright_fraction);
        csq = longint'(c.chroma_sq);
        edge_lv = longint'(c.edge_level);
        sig = (cal_sigma > 0) ? cal_sigma : 1;
        z = sat32(((lum - cal_median) * 65536) / sig);
        den = cal_cthr + csq;
        pen = (den > 0) ? (csq * 65536) / den : 0;
        sb = dark - bright;
        az = (z < 0) ? -z : z;
        cterm = qprod(cal_wc, pen);
        sblk = sat32(qprod(cal_wd, -z) + qprod(cal_ws, sb) - cterm);
        swht = sat32(qprod(cal_wd, z) + qprod(cal_ws, -sb) - cterm);
        semp = sat32(longint'(ssc_pkg::EMPTY_BIAS)
                     - qprod(longint'(ssc_pkg::EMPTY_Z_WEIGHT), az)
                     - qprod(longint'(ssc_pkg::EMPTY_SUPPORT_WEIGHT), dark + bright));
        cls = ssc_pkg::CLS_BLACK;
        best = sblk;
        second = swht;
        if (swht > best)
        begin
            cls = ssc_pkg::CLS_WHITE;
            best = swht;
            second = sblk;
        end
        if (semp > best)
        begin
            cls = ssc_pkg::CLS_EMPTY;
            best = semp;
            second = (sblk > swht) ? sblk : swht;
        end
        else if (semp > second)
            second = semp;
        margin = best - second;
        if (margin > 64'sd2147483647) margin = 64'sd2147483647;
        if (margin < 0) margin = 0;
        factor = 65536 + cal_epen * edge_lv;
        req = cal_mbase * (factor / 65536) + (cal_mbase * (factor % 65536)) / 65536;
        if (req > 64'sd2147483647) req = 64'sd2147483647;
        conf = (margin * 65536) / (req + 1);
        if (conf > 65536) conf = 65536;
        cf = 65536 - qprod(longint'(ssc_pkg::CHROMA_CONF_WEIGHT), pen);
        if (cf < 0) cf = 0;
        if (cf > 65536) cf = 65536;
        conf = (conf * cf) / 65536;
        if (conf > 65536) conf = 65536;
        if (conf < 0) conf = 0;
        v.stone_class = cls;
        v.z_score = z[31:0];
        v.best_score = best[31:0];
        v.second_score = second[31:0];
        v.score_margin = margin[30:0];
        v.required_margin = req[30:0];
        v.confidence = conf[16:0];
        return v;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch at verdict %0d: %s got %0d expected %0d",
                 verdicts_seen, field, got, want);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                verdict_queue.push_back(classify(cell_t'(s_tdata[98:0])));
                cells_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (cell_queue.size() > 0)
                begin
                    s_tdata <= {5'd0, cell_queue.pop_front()};
                    s_tvalid <= 1'b1;
                    in_gap <= gap_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        verdict_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = verdict_t'(m_tdata[176:0]);
                verdicts_seen++;
                if (verdict_queue.size() == 0)
                begin
                    errors++;
                    $display("unexpected verdict %0d", verdicts_seen);
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (got.stone_class !== want.stone_class)
                        report_mismatch("stone_class", got.stone_class, want.stone_class);
                    if (got.z_score !== want.z_score)
                        report_mismatch("z_score", got.z_score, want.z_score);
                    if (got.best_score !== want.best_score)
                        report_mismatch("best_score", got.best_score, want.best_score);
                    if (got.second_score !== want.second_score)
                        report_mismatch("second_score", got.second_score, want.second_score);
                    if (got.score_margin !== want.score_margin)
                        report_mismatch("score_margin", got.score_margin, want.score_margin);
                    if (got.required_margin !== want.required_margin)
                        report_mismatch("required_margin", got.required_margin,
                                        want.required_margin);
                    if (got.confidence !== want.confidence)
                        report_mismatch("confidence", got.confidence, want.confidence);
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_gap <= gap_len();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("watchdog expired with %0d verdicts outstanding", verdict_queue.size());
            $display("stone_score_classifier_test: errors");
            $finish;
        end
    end

    task automatic write_reg(ssc_pkg::cfg_reg_t idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            ssc_pkg::REG_EMPTY_MEDIAN:   cal_median = longint'($signed(value));
            ssc_pkg::REG_EMPTY_SIGMA:    cal_sigma = longint'(value[30:0]);
            ssc_pkg::REG_CHROMA_THR_SQ:  cal_cthr = longint'(value[30:0]);
            ssc_pkg::REG_WEIGHT_DELTA:   cal_wd = longint'($signed(value));
            ssc_pkg::REG_WEIGHT_SUPPORT: cal_ws = longint'($signed(value));
            ssc_pkg::REG_WEIGHT_CHROMA:  cal_wc = longint'($signed(value));
            ssc_pkg::REG_MARGIN_BASE:    cal_mbase = longint'(value[30:0]);
            default:                     cal_epen = longint'(value[30:0]);
        endcase
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 262144) - 131072;
            default: return $urandom();
        endcase
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        c.lum_delta = ($urandom_range(0, 3) == 0) ? pick32() : $urandom_range(0, 1048576) - 524288;
        c.dark_fraction = ($urandom_range(0, 9) == 0) ? 17'($urandom()) :
                          17'($urandom_range(0, 65536));
        c.bright_fraction = ($urandom_range(0, 9) == 0) ? 17'($urandom()) :
                            17'($urandom_range(0, 65536));
        c.chroma_sq = ($urandom_range(0, 2) == 0) ? 31'($urandom()) :
                      31'($urandom_range(0, 262144));
        c.edge_level = 2'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic run_batch(int count);
        for (int i = 0; i < count; i++)
            cell_queue.push_back(random_cell());
        wait (cell_queue.size() == 0 && !s_tvalid && verdict_queue.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        cell_t c;
        cal_median = 0; cal_sigma = 65536; cal_cthr = 65536; cal_wd = 65536;
        cal_ws = 65536; cal_wc = 65536; cal_mbase = 65536; cal_epen = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cells on reset defaults: field extremes, ties, every edge level
        for (int i = 0; i < 20; i++)
        begin
            c.lum_delta = (i % 4 == 0) ? 32'h7FFF_FFFF : (i % 4 == 1) ? 32'h8000_0000 :
                          (i % 4 == 2) ? 32'd0 : 32'hFFFF_0000;
            c.dark_fraction = (i % 5 == 0) ? 17'h1FFFF : (i % 5 == 1) ? 17'd65536 : 17'd0;
            c.bright_fraction = (i % 3 == 0) ? 17'h1FFFF : (i % 3 == 1) ? 17'd0 : 17'd65536;
            c.chroma_sq = (i % 2 == 0) ? 31'h7FFF_FFFF : 31'd0;
            c.edge_level = 2'(i % 4);
            cell_queue.push_back(c);
        end
        wait (cell_queue.size() == 0 && !s_tvalid && verdict_queue.size() == 0);
        repeat (80) @(posedge clk);

        // zero sigma and zero chroma denominator, heavy edge penalty
        write_reg(ssc_pkg::REG_EMPTY_SIGMA, 32'd0);
        write_reg(ssc_pkg::REG_CHROMA_THR_SQ, 32'd0);
        write_reg(ssc_pkg::REG_EDGE_PENALTY, 32'h7FFF_FFFF);
        write_reg(ssc_pkg::REG_MARGIN_BASE, 32'h7FFF_FFFF);
        c = '0;
        cell_queue.push_back(c);
        c.edge_level = 2'd3;
        c.lum_delta = 32'd1;
        cell_queue.push_back(c);
        run_batch(40);
        settings_used++;

        for (int phase = 0; phase < 9; phase++)
        begin
            if (phase == 0)
            begin
                write_reg(ssc_pkg::REG_EMPTY_MEDIAN, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_WEIGHT_DELTA, 32'h8000_0000);
                write_reg(ssc_pkg::REG_WEIGHT_SUPPORT, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_WEIGHT_CHROMA, 32'h8000_0000);
                write_reg(ssc_pkg::REG_EMPTY_SIGMA, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_CHROMA_THR_SQ, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_MARGIN_BASE, 32'd0);
                write_reg(ssc_pkg::REG_EDGE_PENALTY, 32'd0);
            end
            else if (phase == 1)
            begin
                write_reg(ssc_pkg::REG_EMPTY_MEDIAN, 32'h8000_0000);
                write_reg(ssc_pkg::REG_WEIGHT_DELTA, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_WEIGHT_SUPPORT, 32'h8000_0000);
                write_reg(ssc_pkg::REG_WEIGHT_CHROMA, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_EMPTY_SIGMA, 32'd1);
                write_reg(ssc_pkg::REG_CHROMA_THR_SQ, 32'd0);
                write_reg(ssc_pkg::REG_MARGIN_BASE, 32'h7FFF_FFFF);
                write_reg(ssc_pkg::REG_EDGE_PENALTY, 32'h7FFF_FFFF);
            end
            else
            begin
                // realistic settings with random content
                write_reg(ssc_pkg::REG_EMPTY_MEDIAN, $urandom_range(0, 131072) - 65536);
                write_reg(ssc_pkg::REG_EMPTY_SIGMA, $urandom_range(1, 262144));
                write_reg(ssc_pkg::REG_CHROMA_THR_SQ, $urandom_range(0, 262144));
                write_reg(ssc_pkg::REG_WEIGHT_DELTA, $urandom_range(0, 262144) - 131072);
                write_reg(ssc_pkg::REG_WEIGHT_SUPPORT, $urandom_range(0, 262144) - 131072);
                write_reg(ssc_pkg::REG_WEIGHT_CHROMA, ($urandom_range(0, 3) == 0) ? $urandom() :
                          $urandom_range(0, 131072));
                write_reg(ssc_pkg::REG_MARGIN_BASE, $urandom_range(0, 3) == 0 ? $urandom() >> 1 :
                          $urandom_range(0, 262144));
                write_reg(ssc_pkg::REG_EDGE_PENALTY, $urandom_range(0, 131072));
            end
            settings_used++;
            run_batch(200);
        end

        $display("%0d cells classified under %0d register settings, %0d verdicts checked",
                 cells_sent, settings_used + 1, verdicts_seen);
        if (errors == 0)
            $display("stone_score_classifier_test: clean");
        else
            $display("stone_score_classifier_test: errors");
        $finish;
    end
endmodule
